// File: design/msf_pkg.sv
// Shared types, constants and helper functions of the maximum-sum submatrix finder.
// No dependencies; used by msf_ctrl, msf_dpath and max_submatrix_sum_finder.
package msf_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;

  localparam int ELEM_W     = 16;
  localparam int CNT_W      = 5;
  localparam int IDX_OUT_W  = 4;
  localparam int SUM_OUT_W  = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // column prefix, band column sum, running band sum
  localparam int PFX_W  = ELEM_W + $clog2(MAX_ROWS);
  localparam int BAND_W = PFX_W + 1;
  localparam int RUN_W  = PFX_W + $clog2(MAX_COLS) + 1;
  localparam int SAT_W  = (RUN_W > SUM_OUT_W) ? RUN_W : SUM_OUT_W;

  localparam int SUM_MAX = 2 ** (SUM_OUT_W - 1) - 1;
  localparam int SUM_MIN = -(2 ** (SUM_OUT_W - 1));

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = CFG_IDX_W'(0),
    REG_COL_COUNT = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             load_en;
    logic [ROW_W-1:0] load_row;
    logic [COL_W-1:0] load_col;
    logic             scan_en;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bot;
    logic [COL_W-1:0] col;
    logic             first_item;
    logic             last_item;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  // Index of the last row in use: zero count acts as one, oversized clips.
  function automatic logic [ROW_W-1:0] last_row_idx(logic [CNT_W-1:0] cnt);
    logic [7:0] eff;
    if (cnt == '0) begin
      eff = 8'd1;
    end else if (int'(cnt) > MAX_ROWS) begin
      eff = 8'(MAX_ROWS);
    end else begin
      eff = 8'(cnt);
    end
    return ROW_W'(eff - 8'd1);
  endfunction

  function automatic logic [COL_W-1:0] last_col_idx(logic [CNT_W-1:0] cnt);
    logic [7:0] eff;
    if (cnt == '0) begin
      eff = 8'd1;
    end else if (int'(cnt) > MAX_COLS) begin
      eff = 8'(MAX_COLS);
    end else begin
      eff = 8'(cnt);
    end
    return COL_W'(eff - 8'd1);
  endfunction

endpackage

// File: design/msf_dpath.sv
// Datapath: column prefix memory, load accumulators, band-sum pipeline, Kadane
// scan with best tracking, and the result register. Depends on msf_pkg.
module msf_dpath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  msf_pkg::cmd_t                          cmd_i,
  input  logic signed [msf_pkg::ELEM_W-1:0]      elem_i,
  output msf_pkg::sts_t                          sts_o,
  output logic [msf_pkg::IDX_OUT_W-1:0]          top_row_o,
  output logic [msf_pkg::IDX_OUT_W-1:0]          left_col_o,
  output logic [msf_pkg::IDX_OUT_W-1:0]          bottom_row_o,
  output logic [msf_pkg::IDX_OUT_W-1:0]          right_col_o,
  output logic signed [msf_pkg::SUM_OUT_W-1:0]   best_sum_o
);

  typedef struct packed {
    logic                      top_zero;
    logic                      first_col;
    logic                      first_item;
    logic                      last_item;
    logic [msf_pkg::ROW_W-1:0] top;
    logic [msf_pkg::ROW_W-1:0] bot;
    logic [msf_pkg::COL_W-1:0] col;
  } stage_t;

  // mem_q[r*MAX_COLS+c] holds the sum of column c over rows 0..r
  logic signed [msf_pkg::PFX_W-1:0]  mem_q [msf_pkg::DEPTH];
  logic signed [msf_pkg::PFX_W-1:0]  acc_q [msf_pkg::MAX_COLS];
  logic signed [msf_pkg::PFX_W-1:0]  acc_new;
  logic [msf_pkg::ADDR_W-1:0]        wr_addr, rd_a_addr, rd_b_addr;
  logic signed [msf_pkg::PFX_W-1:0]  rd_a_q, rd_b_q;

  logic                              s1_vld_q, s2_vld_q;
  stage_t                            s1_d, s1_q, s2_q;
  logic signed [msf_pkg::BAND_W-1:0] band_d, band_q;

  logic signed [msf_pkg::RUN_W-1:0]  run_d, run_q, best_q;
  logic [msf_pkg::COL_W-1:0]         start_d, start_q;
  logic                              restart, better;
  logic [msf_pkg::ROW_W-1:0]         best_top_q, best_bot_q;
  logic [msf_pkg::COL_W-1:0]         best_left_q, best_right_q;

  logic signed [msf_pkg::SAT_W-1:0]  best_ext;
  logic signed [msf_pkg::SUM_OUT_W-1:0] sum_sat;

  // Load path
  always_comb begin
    if (cmd_i.load_row == '0) begin
      acc_new = msf_pkg::PFX_W'(elem_i);
    end else begin
      acc_new = acc_q[cmd_i.load_col] + msf_pkg::PFX_W'(elem_i);
    end
    wr_addr   = msf_pkg::ADDR_W'(cmd_i.load_row * msf_pkg::MAX_COLS + cmd_i.load_col);
    rd_a_addr = msf_pkg::ADDR_W'(cmd_i.bot * msf_pkg::MAX_COLS + cmd_i.col);
    rd_b_addr = msf_pkg::ADDR_W'((cmd_i.top - 1'b1) * msf_pkg::MAX_COLS + cmd_i.col);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      mem_q[wr_addr]        <= acc_new;
      acc_q[cmd_i.load_col] <= acc_new;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  // Band pipeline control
  always_comb begin
    s1_d.top_zero   = (cmd_i.top == '0);
    s1_d.first_col  = (cmd_i.col == '0);
    s1_d.first_item = cmd_i.first_item;
    s1_d.last_item  = cmd_i.last_item;
    s1_d.top        = cmd_i.top;
    s1_d.bot        = cmd_i.bot;
    s1_d.col        = cmd_i.col;

    // the row above the top row is the zero border when top is row 0
    if (s1_q.top_zero) begin
      band_d = msf_pkg::BAND_W'(rd_a_q);
    end else begin
      band_d = msf_pkg::BAND_W'(rd_a_q) - msf_pkg::BAND_W'(rd_b_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.scan_en;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= s1_d;
    s2_q   <= s1_q;
    band_q <= band_d;
  end

  // Kadane step
  always_comb begin
    restart = s2_q.first_col || (run_q < 0);
    if (restart) begin
      run_d   = msf_pkg::RUN_W'(band_q);
      start_d = s2_q.col;
    end else begin
      run_d   = run_q + msf_pkg::RUN_W'(band_q);
      start_d = start_q;
    end
    better = s2_q.first_item || (run_d > best_q);
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      run_q   <= run_d;
      start_q <= start_d;
      if (better) begin
        best_q       <= run_d;
        best_top_q   <= s2_q.top;
        best_left_q  <= start_d;
        best_bot_q   <= s2_q.bot;
        best_right_q <= s2_q.col;
      end
    end
  end

  assign sts_o.scan_done = s2_vld_q && s2_q.last_item;

  // Clamp to the result range
  always_comb begin
    best_ext = msf_pkg::SAT_W'(best_q);
    if (best_ext > msf_pkg::SAT_W'(msf_pkg::SUM_MAX)) begin
      sum_sat = msf_pkg::SUM_OUT_W'(msf_pkg::SUM_MAX);
    end else if (best_ext < msf_pkg::SAT_W'(msf_pkg::SUM_MIN)) begin
      sum_sat = msf_pkg::SUM_OUT_W'(msf_pkg::SUM_MIN);
    end else begin
      sum_sat = best_ext[msf_pkg::SUM_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      top_row_o    <= msf_pkg::IDX_OUT_W'(best_top_q);
      left_col_o   <= msf_pkg::IDX_OUT_W'(best_left_q);
      bottom_row_o <= msf_pkg::IDX_OUT_W'(best_bot_q);
      right_col_o  <= msf_pkg::IDX_OUT_W'(best_right_q);
      best_sum_o   <= sum_sat;
    end
  end

endmodule

// File: design/msf_ctrl.sv
// Controller: count registers, load position, band/column sequencer and the
// result handshake. Depends on msf_pkg; drives msf_dpath through cmd_t.
module msf_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic                              m_ready_i,
  output logic                              m_valid_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [msf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  msf_pkg::sts_t                     sts_i,
  output msf_pkg::cmd_t                     cmd_o
);

  msf_pkg::state_e             state_d, state_q;
  logic [msf_pkg::CNT_W-1:0]   row_cnt_d, row_cnt_q, col_cnt_d, col_cnt_q;
  logic [msf_pkg::ROW_W-1:0]   load_row_d, load_row_q, top_d, top_q, bot_d, bot_q;
  logic [msf_pkg::COL_W-1:0]   load_col_d, load_col_q, col_d, col_q;
  logic                        out_valid_d, out_valid_q;
  logic [msf_pkg::ROW_W-1:0]   last_row;
  logic [msf_pkg::COL_W-1:0]   last_col;
  logic                        in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msf_pkg::ST_LOAD;
      row_cnt_q   <= msf_pkg::CNT_RESET;
      col_cnt_q   <= msf_pkg::CNT_RESET;
      load_row_q  <= '0;
      load_col_q  <= '0;
      top_q       <= '0;
      bot_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      top_q       <= top_d;
      bot_q       <= bot_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    last_row    = msf_pkg::last_row_idx(row_cnt_q);
    last_col    = msf_pkg::last_col_idx(col_cnt_q);
    s_ready_o   = (state_q == msf_pkg::ST_LOAD);
    cfg_ready_o = 1'b1;
    m_valid_o   = out_valid_q;
    in_fire     = s_valid_i && s_ready_o;

    state_d    = state_q;
    row_cnt_d  = row_cnt_q;
    col_cnt_d  = col_cnt_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    top_d      = top_q;
    bot_d      = bot_q;
    col_d      = col_q;
    cmd_o      = '0;

    cmd_o.load_row = load_row_q;
    cmd_o.load_col = load_col_q;
    cmd_o.top      = top_q;
    cmd_o.bot      = bot_q;
    cmd_o.col      = col_q;

    case (state_q)
      msf_pkg::ST_LOAD: begin
        if (in_fire) begin
          cmd_o.load_en = 1'b1;
          if (load_col_q == last_col) begin
            load_col_d = '0;
            if (load_row_q == last_row) begin
              // matrix complete: start the band scan
              load_row_d = '0;
              top_d      = '0;
              bot_d      = '0;
              col_d      = '0;
              state_d    = msf_pkg::ST_SCAN;
            end else begin
              load_row_d = load_row_q + 1'b1;
            end
          end else begin
            load_col_d = load_col_q + 1'b1;
          end
        end
      end
      msf_pkg::ST_SCAN: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.first_item = (top_q == '0) && (bot_q == '0) && (col_q == '0);
        cmd_o.last_item  = (top_q == last_row) && (bot_q == last_row) && (col_q == last_col);
        if (col_q == last_col) begin
          col_d = '0;
          if (bot_q == last_row) begin
            if (top_q == last_row) begin
              state_d = msf_pkg::ST_DRAIN;
            end else begin
              top_d = top_q + 1'b1;
              bot_d = top_q + 1'b1;
            end
          end else begin
            bot_d = bot_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      msf_pkg::ST_DRAIN: begin
        if (sts_i.scan_done) begin
          state_d = msf_pkg::ST_OUT;
        end
      end
      msf_pkg::ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = msf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = msf_pkg::ST_LOAD;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msf_pkg::REG_ROW_COUNT: begin
          row_cnt_d  = cfg_data_i[msf_pkg::CNT_W-1:0];
          load_row_d = '0;
          load_col_d = '0;
        end
        msf_pkg::REG_COL_COUNT: begin
          col_cnt_d  = cfg_data_i[msf_pkg::CNT_W-1:0];
          load_row_d = '0;
          load_col_d = '0;
        end
        default: begin
          row_cnt_d = row_cnt_q;
        end
      endcase
    end
  end

endmodule

// File: design/max_submatrix_sum_finder.sv
// Top level of the maximum-sum submatrix finder (two-dimensional Kadane).
// Depends on msf_pkg, msf_ctrl and msf_dpath.
//
//   channel   | direction | transfer carries
//   ----------+-----------+-----------------------------------------------
//   s_axis    | in        | one matrix element, row-major
//   m_axis    | out       | corners and sum of the best submatrix
//   cfg       | in        | register index and value (row_count, col_count)
//
// One element loads per cycle. After the last element the band sequencer issues
// one column per cycle over all top/bottom row pairs, then the pipeline behind the
// prefix memory read port drains and the result loads. s_axis_tready stays low over
// that span, and longer while an earlier result is still held on m_axis; loading
// itself ignores m_axis_tready.
// After reset the counts are 16 x 16; a count write restarts loading.
module max_submatrix_sum_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [msf_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [15:0] elem_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] top_row, [7:4] left_col, [11:8] bottom_row, [15:12] right_col,
  // [39:16] best_sum
  output logic [msf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [msf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  msf_pkg::cmd_t                          cmd;
  msf_pkg::sts_t                          sts;
  logic [msf_pkg::IDX_OUT_W-1:0]          top_row, left_col, bottom_row, right_col;
  logic signed [msf_pkg::SUM_OUT_W-1:0]   best_sum;

  msf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msf_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .elem_i       (s_axis_tdata[msf_pkg::ELEM_W-1:0]),
    .sts_o        (sts),
    .top_row_o    (top_row),
    .left_col_o   (left_col),
    .bottom_row_o (bottom_row),
    .right_col_o  (right_col),
    .best_sum_o   (best_sum)
  );

  assign m_axis_tdata = {best_sum, right_col, bottom_row, left_col, top_row};

endmodule
